[src/trc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trc_pkg: shared types and constants of the residency counter
// Beat formats, operation codes, register indexes and control structs.
// ----------------------------------------------------------------------------
package trc_pkg;

  localparam int NUM_THR = 6;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_REPORT = 2'd2;

  localparam logic [2:0] REG_THR_COUNT = 3'd0;
  localparam logic [2:0] REG_THR_FIRST = 3'd1;
  localparam logic [2:0] REG_THR_LAST  = 3'd6;

  localparam logic signed [15:0] READING_MIN = 16'sh8000;
  localparam logic signed [15:0] READING_MAX = 16'sh7FFF;

  typedef logic signed [15:0] trc_reading_t;

  typedef struct packed {
    logic [1:0]   operation;
    trc_reading_t sample_value;
  } trc_in_t;

  typedef struct packed {
    logic [2:0]   bucket_index;
    logic [31:0]  residency_ticks;
    logic [31:0]  period_ticks;
    trc_reading_t max_reading;
    trc_reading_t min_reading;
    logic         last_bucket;
  } trc_out_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [15:0] value;
  } trc_cfg_t;

  typedef struct packed {
    logic sample;
    logic tick;
    logic load;
    logic clear;
  } trc_cmd_t;

  typedef struct packed {
    logic out_full;
    logic idx_last;
  } trc_sts_t;

endpackage

[src/trc_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trc_stream_if: valid/ready channel
// Carries one beat of type data_t per handshake.
// ----------------------------------------------------------------------------
interface trc_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/trc_classify.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trc_classify: bucket classifier
// Counts thresholds at or below the reading, or with none set uses integer degrees.
// ----------------------------------------------------------------------------
module trc_classify #(
  parameter int BUCKETS = 8,
  localparam int BW = $clog2(BUCKETS)
) (
  input  logic [2:0]            thr_count_i,
  input  trc_pkg::trc_reading_t thr_i [trc_pkg::NUM_THR],
  input  trc_pkg::trc_reading_t value_i,
  output logic [BW-1:0]         bucket_o
);
  import trc_pkg::*;

  localparam logic [11:0] MAX_BUCKET = 12'(BUCKETS - 1);

  logic [2:0]  n_use;
  logic [2:0]  hits;
  logic [11:0] raw;

  always_comb begin
    n_use = (thr_count_i > 3'(NUM_THR)) ? 3'(NUM_THR) : thr_count_i;
    hits  = '0;
    for (int i = 0; i < NUM_THR; i++) begin
      if ((3'(i) < n_use) && (thr_i[i] <= value_i)) begin
        hits = hits + 3'd1;
      end
    end
    if (n_use == '0) begin
      raw = value_i[15] ? 12'd0 : 12'(value_i[14:4]);
    end else begin
      raw = 12'(hits);
    end
    bucket_o = (raw > MAX_BUCKET) ? BW'(MAX_BUCKET) : BW'(raw);
  end

endmodule

[src/trc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trc_ctrl: operation sequencer
// Decodes accepted items and steps the report run one beat at a time.
// ----------------------------------------------------------------------------
module trc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_op_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  input  trc_pkg::trc_sts_t sts_i,
  output trc_pkg::trc_cmd_t cmd_o
);
  import trc_pkg::*;

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_REPORT = 1'b1;

  logic state_q, state_d;
  logic accept;
  logic can_load;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign can_load   = !sts_i.out_full || out_ready_i;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_op_i)
            OP_SAMPLE: cmd_o.sample = 1'b1;
            OP_TICK:   cmd_o.tick = 1'b1;
            OP_REPORT: state_d = ST_REPORT;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_REPORT: begin
        if (can_load) begin
          cmd_o.load = 1'b1;
          if (sts_i.idx_last) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[src/trc_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trc_dp: residency datapath
// Threshold registers, counters, max/min trackers and the result register.
// ----------------------------------------------------------------------------
module trc_dp #(
  parameter int BUCKETS       = 8,
  parameter int COUNTER_WIDTH = 32,
  localparam int BW = $clog2(BUCKETS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  trc_pkg::trc_cfg_t     cfg_data_i,
  output logic                  cfg_ready_o,
  input  trc_pkg::trc_reading_t sample_i,
  input  trc_pkg::trc_cmd_t     cmd_i,
  output trc_pkg::trc_sts_t     sts_o,
  output logic                  out_valid_o,
  output trc_pkg::trc_out_t     out_data_o,
  input  logic                  out_ready_i
);
  import trc_pkg::*;

  localparam logic [BW-1:0] LAST_IDX = BW'(BUCKETS - 1);

  logic [2:0]               thr_count_q;
  trc_reading_t             thr_q [NUM_THR];
  logic [BW-1:0]            cur_q;
  logic [BW-1:0]            idx_q;
  logic [BW-1:0]            new_bucket;
  logic [BW-1:0]            rd_addr;
  logic [COUNTER_WIDTH-1:0] resid_q [BUCKETS];
  logic [COUNTER_WIDTH-1:0] rd_cnt;
  logic [COUNTER_WIDTH-1:0] period_q;
  trc_reading_t             max_q;
  trc_reading_t             min_q;
  logic                     out_valid_q;
  trc_out_t                 out_q;

  function automatic logic [COUNTER_WIDTH-1:0] sat_inc(input logic [COUNTER_WIDTH-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  trc_classify #(
    .BUCKETS(BUCKETS)
  ) u_classify (
    .thr_count_i(thr_count_q),
    .thr_i      (thr_q),
    .value_i    (sample_i),
    .bucket_o   (new_bucket)
  );

  assign cfg_ready_o    = 1'b1;
  assign rd_addr        = cmd_i.load ? idx_q : cur_q;
  assign rd_cnt         = resid_q[rd_addr];
  assign sts_o.out_full = out_valid_q;
  assign sts_o.idx_last = (idx_q == LAST_IDX);
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_count_q <= '0;
      for (int i = 0; i < NUM_THR; i++) begin
        thr_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      if (cfg_data_i.index == REG_THR_COUNT) begin
        thr_count_q <= cfg_data_i.value[2:0];
      end else if (cfg_data_i.index <= REG_THR_LAST) begin
        thr_q[cfg_data_i.index - REG_THR_FIRST] <= cfg_data_i.value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q    <= '0;
      idx_q    <= '0;
      period_q <= '0;
      max_q    <= READING_MIN;
      min_q    <= READING_MAX;
      for (int i = 0; i < BUCKETS; i++) begin
        resid_q[i] <= '0;
      end
    end else begin
      if (cmd_i.sample) begin
        cur_q <= new_bucket;
        if (sample_i > max_q) begin
          max_q <= sample_i;
        end
        if (sample_i < min_q) begin
          min_q <= sample_i;
        end
      end
      if (cmd_i.tick) begin
        resid_q[cur_q] <= sat_inc(rd_cnt);
        period_q       <= sat_inc(period_q);
      end
      if (cmd_i.clear) begin
        idx_q    <= '0;
        period_q <= '0;
        max_q    <= READING_MIN;
        min_q    <= READING_MAX;
        for (int i = 0; i < BUCKETS; i++) begin
          resid_q[i] <= '0;
        end
      end else if (cmd_i.load) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q.bucket_index    <= 3'(idx_q);
      out_q.residency_ticks <= 32'(rd_cnt);
      out_q.period_ticks    <= 32'(period_q);
      out_q.max_reading     <= max_q;
      out_q.min_reading     <= min_q;
      out_q.last_bucket     <= (idx_q == LAST_IDX);
    end
  end

`ifndef ASSERT_OFF
  a_load_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before it was taken");

  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |-> (cmd_i.load && idx_q == LAST_IDX))
    else $error("counters cleared before the last bucket was read");

  a_clear_resets_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (period_q == '0 && idx_q == '0))
    else $error("period counter or report index not cleared");

  a_sample_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sample |=> (max_q >= min_q))
    else $error("max reading below min reading after a sample");

  a_bucket_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= LAST_IDX)
    else $error("current bucket out of range");
`endif

endmodule

[src/threshold_bucket_residency_counter.sv]
`timescale 1ns / 1ps
// Samples and ticks: one beat per cycle while no report runs, no result, state updated
// at the accepting edge. Report: holds the input side until the last bucket is loaded;
// the first result beat goes through the report state and result register, then one beat
// per cycle while the receiver takes them. Reset: thresholds, counters, current bucket
// clear to zero, max to -32768, min to 32767, all at once; input is ready out of reset.
// ----------------------------------------------------------------------------
// threshold_bucket_residency_counter: time-in-bucket residency histogram
// Classifies readings into buckets, counts ticks per bucket and reports them.
// ----------------------------------------------------------------------------
module threshold_bucket_residency_counter #(
  parameter int BUCKETS       = 8,
  parameter int COUNTER_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  trc_stream_if.sink   in_i,
  trc_stream_if.source out_o,
  trc_stream_if.sink   cfg_i
);
  import trc_pkg::*;

  trc_cmd_t cmd;
  trc_sts_t sts;
  trc_in_t  in_beat;
  trc_cfg_t cfg_beat;
  trc_out_t out_beat;
  logic     in_ready;
  logic     cfg_ready;
  logic     out_valid;

  assign in_beat     = in_i.data;
  assign cfg_beat    = cfg_i.data;
  assign in_i.ready  = in_ready;
  assign cfg_i.ready = cfg_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_beat;

  trc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_beat.operation),
    .in_ready_o (in_ready),
    .out_ready_i(out_o.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  trc_dp #(
    .BUCKETS      (BUCKETS),
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_i.valid),
    .cfg_data_i (cfg_beat),
    .cfg_ready_o(cfg_ready),
    .sample_i   (in_beat.sample_value),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(out_valid),
    .out_data_o (out_beat),
    .out_ready_i(out_o.ready)
  );

endmodule
